[hdl/snes_pkg.sv]
// Shared constants and helper functions for the game pad serial reader.
package snes_pkg;

    localparam int unsigned SERIAL_BITS = 17;
    localparam int unsigned BTN_W = 13;
    localparam int unsigned HALF_W = 16;
    localparam int unsigned TICK_W = 17;
    localparam int unsigned BIT_IDX_W = 5;

    localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd6;

    localparam logic [BTN_W-1:0] BTN_UP = 13'h0008;
    localparam logic [BTN_W-1:0] BTN_DOWN = 13'h0010;
    localparam logic [BTN_W-1:0] BTN_LEFT = 13'h0020;
    localparam logic [BTN_W-1:0] BTN_RIGHT = 13'h0040;

    // Output bit for each serial position; the four spare positions set nothing.
    function automatic logic [BTN_W-1:0] serial_map(input logic [BIT_IDX_W-1:0] idx);
        logic [BTN_W-1:0] mask;
        begin
            unique case (idx)
                5'd0: mask = 13'h0200;
                5'd1: mask = 13'h0400;
                5'd2: mask = 13'h0002;
                5'd3: mask = 13'h0004;
                5'd4: mask = 13'h0008;
                5'd5: mask = 13'h0010;
                5'd6: mask = 13'h0020;
                5'd7: mask = 13'h0040;
                5'd8: mask = 13'h0080;
                5'd9: mask = 13'h0100;
                5'd10: mask = 13'h0800;
                5'd11: mask = 13'h1000;
                5'd16: mask = 13'h0001;
                default: mask = '0;
            endcase
            return mask;
        end
    endfunction

    // Clears both buttons of a pair when both are pressed.
    function automatic logic [BTN_W-1:0] drop_opposite(input logic [BTN_W-1:0] word,
                                                       input logic [BTN_W-1:0] pair);
        begin
            if ((word & pair) == pair)
                return word & ~pair;
            return word;
        end
    endfunction

endpackage

[hdl/snes_pad_reader.sv]
// Result: a result word appears in the output register in the cycle after its tick is accepted.
// Throughput: one tick word per cycle; the sequencer and the output register both advance
// whenever a tick word is offered and the output register is empty or being drained in the same cycle.
// Reset (rst_n low, asynchronous): sequencer idle, counters and collected bits cleared,
// last button word zero, half period back to 6, output register empty.
// Top level of the game pad serial reader: sequencer, bit collection and output register.
module snes_pad_reader (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [snes_pkg::HALF_W-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              start_read,
    input  logic                              data_line,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              latch_out,
    output logic                              clock_out,
    output logic                              busy_res,
    output logic                              done_res,
    output logic [snes_pkg::BTN_W-1:0]        buttons
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_LATCH = 3'd1,
        PH_WAIT  = 3'd2,
        PH_LOW   = 3'd3,
        PH_HIGH  = 3'd4
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [snes_pkg::TICK_W-1:0]     tick_count_reg, tick_count_next;
    logic [snes_pkg::BIT_IDX_W-1:0]  bit_index_reg, bit_index_next;
    logic [snes_pkg::BTN_W-1:0]      gathered_reg, gathered_next;
    logic [snes_pkg::BTN_W-1:0]      last_buttons_reg, last_buttons_next;
    logic [snes_pkg::HALF_W-1:0]     half_period_reg;

    logic                            out_valid_reg;
    logic                            latch_reg, clock_reg, busy_reg, done_reg;
    logic                            done_next;

    logic                            in_fire;
    logic [snes_pkg::HALF_W-1:0]     half_eff;
    logic [snes_pkg::TICK_W-1:0]     half_ext, full_ext, tick_inc;
    logic [snes_pkg::BIT_IDX_W-1:0]  bit_inc;
    logic [snes_pkg::BTN_W-1:0]      word;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign half_eff = (half_period_reg == '0) ? snes_pkg::HALF_W'(1) : half_period_reg;
    assign half_ext = {1'b0, half_eff};
    assign full_ext = {half_eff, 1'b0};
    assign tick_inc = tick_count_reg + snes_pkg::TICK_W'(1);
    assign bit_inc  = bit_index_reg + snes_pkg::BIT_IDX_W'(1);

    always_comb
    begin
        phase_next        = phase_reg;
        tick_count_next   = tick_count_reg;
        bit_index_next    = bit_index_reg;
        gathered_next     = gathered_reg;
        last_buttons_next = last_buttons_reg;
        done_next         = 1'b0;
        word              = gathered_reg;

        unique case (phase_reg)
            PH_LATCH:
            begin
                tick_count_next = tick_inc;
                if (tick_inc >= full_ext)
                begin
                    phase_next      = PH_WAIT;
                    tick_count_next = '0;
                end
            end
            PH_WAIT:
            begin
                tick_count_next = tick_inc;
                if (tick_inc >= half_ext)
                begin
                    phase_next      = PH_LOW;
                    tick_count_next = '0;
                end
            end
            PH_LOW:
            begin
                tick_count_next = tick_inc;
                if (tick_inc >= half_ext)
                begin
                    if (!data_line && bit_index_reg < snes_pkg::BIT_IDX_W'(snes_pkg::SERIAL_BITS))
                        gathered_next = gathered_reg | snes_pkg::serial_map(bit_index_reg);
                    phase_next      = PH_HIGH;
                    tick_count_next = '0;
                end
            end
            PH_HIGH:
            begin
                tick_count_next = tick_inc;
                if (tick_inc >= half_ext)
                begin
                    tick_count_next = '0;
                    bit_index_next  = bit_inc;
                    if (bit_inc >= snes_pkg::BIT_IDX_W'(snes_pkg::SERIAL_BITS))
                    begin
                        // A pad that never pulled the last bit low is reported as absent.
                        if (gathered_reg[0])
                        begin
                            word = snes_pkg::drop_opposite(gathered_reg,
                                                           snes_pkg::BTN_UP | snes_pkg::BTN_DOWN);
                            word = snes_pkg::drop_opposite(word,
                                                           snes_pkg::BTN_LEFT | snes_pkg::BTN_RIGHT);
                        end
                        else
                        begin
                            word = '0;
                        end
                        last_buttons_next = word;
                        done_next         = 1'b1;
                        phase_next        = PH_IDLE;
                        bit_index_next    = '0;
                    end
                    else
                    begin
                        phase_next = PH_LOW;
                    end
                end
            end
            default:
            begin
                // Idle, and any code outside the sequence, waits for a start request.
                phase_next = PH_IDLE;
                if (start_read)
                begin
                    phase_next      = PH_LATCH;
                    tick_count_next = '0;
                    bit_index_next  = '0;
                    gathered_next   = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_period_reg <= snes_pkg::HALF_PERIOD_RESET;
        else if (cfg_we)
            half_period_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            tick_count_reg   <= '0;
            bit_index_reg    <= '0;
            gathered_reg     <= '0;
            last_buttons_reg <= '0;
            out_valid_reg    <= 1'b0;
            latch_reg        <= 1'b0;
            clock_reg        <= 1'b1;
            busy_reg         <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg        <= phase_next;
                tick_count_reg   <= tick_count_next;
                bit_index_reg    <= bit_index_next;
                gathered_reg     <= gathered_next;
                last_buttons_reg <= last_buttons_next;
                out_valid_reg    <= 1'b1;
                latch_reg        <= (phase_next == PH_LATCH);
                clock_reg        <= (phase_next != PH_LOW);
                busy_reg         <= (phase_next != PH_IDLE);
                done_reg         <= done_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign latch_out = latch_reg;
    assign clock_out = clock_reg;
    assign busy_res  = busy_reg;
    assign done_res  = done_reg;
    assign buttons   = last_buttons_reg;

`ifndef SYNTHESIS
    // The sequence has ended on the word that reports new buttons.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> !busy_res)
        else $error("done word reported while busy");

    // Latch high and clock low only happen inside a read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (latch_out || !clock_out)) |-> busy_res)
        else $error("pad lines active outside a read");

    // An absent pad always reads as an all-zero word.
    assert property (@(posedge clk) disable iff (!rst_n)
        !buttons[0] |-> (buttons == '0))
        else $error("buttons set without a connected pad");

    // Opposite directions are never reported together.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(buttons[3] && buttons[4]) && !(buttons[5] && buttons[6]))
        else $error("opposite directions both reported");

    // The buttons word changes only on a done word.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(buttons) |-> (out_valid && done_res))
        else $error("buttons changed without a done word");
`endif

endmodule

[verif/tb.sv]
// Self-checking testbench for the game pad serial reader, one tick word per handshake.
module tb;

    typedef enum bit [2:0] {
        RD_IDLE,
        RD_LATCH,
        RD_WAIT,
        RD_LOW,
        RD_HIGH
    } read_phase_t;

    typedef struct {
        bit                         latch;
        bit                         pad_clk;
        bit                         busy;
        bit                         done;
        bit [snes_pkg::BTN_W-1:0]   btn;
    } pad_sample_t;

    // Button slot for each serial position; -1 marks the spare positions.
    localparam int PAD_SLOT [snes_pkg::SERIAL_BITS] = '{9, 10, 1, 2, 3, 4, 5, 6, 7, 8, 11, 12,
                                                        -1, -1, -1, -1, 0};
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;

    class pad_word_tracker;
        bit [snes_pkg::HALF_W-1:0]    half_ticks;
        read_phase_t                  phase;
        bit [snes_pkg::TICK_W-1:0]    tick_cnt;
        bit [snes_pkg::BIT_IDX_W-1:0] bit_pos;
        bit [snes_pkg::BTN_W-1:0]     collected;
        bit [snes_pkg::BTN_W-1:0]     last_word;
        pad_sample_t                  expected_words[$];
        int                           errors;

        function new();
            half_ticks = snes_pkg::HALF_PERIOD_RESET;
            phase = RD_IDLE;
            tick_cnt = '0;
            bit_pos = '0;
            collected = '0;
            last_word = '0;
            errors = 0;
        endfunction

        function void set_half(bit [snes_pkg::HALF_W-1:0] v);
            half_ticks = v;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // Advances the sequencer by one tick and queues the word it must produce.
        function void note_tick(bit start, bit data);
            bit [snes_pkg::TICK_W:0]  h;
            bit                       done;
            bit [snes_pkg::BTN_W-1:0] w;
            pad_sample_t              s;
            h = (half_ticks == '0) ? 18'd1 : {2'b00, half_ticks};
            done = 1'b0;
            if (phase == RD_IDLE) begin
                if (start) begin
                    phase = RD_LATCH;
                    tick_cnt = '0;
                    bit_pos = '0;
                    collected = '0;
                end
            end
            else begin
                tick_cnt = tick_cnt + 1'b1;
                case (phase)
                    RD_LATCH:
                        if (tick_cnt >= (h << 1)) begin
                            phase = RD_WAIT;
                            tick_cnt = '0;
                        end
                    RD_WAIT:
                        if (tick_cnt >= h) begin
                            phase = RD_LOW;
                            tick_cnt = '0;
                        end
                    RD_LOW:
                        if (tick_cnt >= h) begin
                            if (!data && bit_pos < snes_pkg::SERIAL_BITS &&
                                PAD_SLOT[bit_pos] >= 0)
                                collected[PAD_SLOT[bit_pos]] = 1'b1;
                            phase = RD_HIGH;
                            tick_cnt = '0;
                        end
                    default:
                        if (tick_cnt >= h) begin
                            tick_cnt = '0;
                            bit_pos = bit_pos + 1'b1;
                            if (bit_pos >= snes_pkg::SERIAL_BITS) begin
                                w = collected;
                                // A pad that did not answer on the last bit reads as all zero.
                                if (w[0]) begin
                                    if ((w & (snes_pkg::BTN_UP | snes_pkg::BTN_DOWN)) ==
                                        (snes_pkg::BTN_UP | snes_pkg::BTN_DOWN))
                                        w = w & ~(snes_pkg::BTN_UP | snes_pkg::BTN_DOWN);
                                    if ((w & (snes_pkg::BTN_LEFT | snes_pkg::BTN_RIGHT)) ==
                                        (snes_pkg::BTN_LEFT | snes_pkg::BTN_RIGHT))
                                        w = w & ~(snes_pkg::BTN_LEFT | snes_pkg::BTN_RIGHT);
                                end
                                else begin
                                    w = '0;
                                end
                                last_word = w;
                                done = 1'b1;
                                phase = RD_IDLE;
                                bit_pos = '0;
                            end
                            else begin
                                phase = RD_LOW;
                            end
                        end
                endcase
            end
            s.latch = (phase == RD_LATCH);
            s.pad_clk = (phase != RD_LOW);
            s.busy = (phase != RD_IDLE);
            s.done = done;
            s.btn = last_word;
            expected_words.push_back(s);
        endfunction

        function void check_word(logic latch, logic pad_clk, logic busy, logic done,
                                 logic [snes_pkg::BTN_W-1:0] btn);
            pad_sample_t e;
            if (expected_words.size() == 0) begin
                $error("result word arrived with no tick outstanding");
                errors++;
                return;
            end
            e = expected_words.pop_front();
            if (latch !== e.latch) begin
                $error("latch_out: expected %0d, got %0d", e.latch, latch);
                errors++;
            end
            if (pad_clk !== e.pad_clk) begin
                $error("clock_out: expected %0d, got %0d", e.pad_clk, pad_clk);
                errors++;
            end
            if (busy !== e.busy) begin
                $error("busy_res: expected %0d, got %0d", e.busy, busy);
                errors++;
            end
            if (done !== e.done) begin
                $error("done_res: expected %0d, got %0d", e.done, done);
                errors++;
            end
            if (btn !== e.btn) begin
                $error("buttons: expected %0h, got %0h", e.btn, btn);
                errors++;
            end
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [snes_pkg::HALF_W-1:0]   cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic                          start_read = 1'b0;
    logic                          data_line = 1'b1;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic                          latch_out;
    logic                          clock_out;
    logic                          busy_res;
    logic                          done_res;
    logic [snes_pkg::BTN_W-1:0]    buttons;

    pad_word_tracker                 sb = new();
    bit [snes_pkg::SERIAL_BITS-1:0]  pad_pressed;
    int                              ticks_sent = 0;
    int                              words_seen = 0;
    int                              hold_left = 0;
    bit                              held_once = 1'b0;
    int                              quiet_cycles = 0;

    snes_pad_reader dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .start_read (start_read),
        .data_line  (data_line),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .latch_out  (latch_out),
        .clock_out  (clock_out),
        .busy_res   (busy_res),
        .done_res   (done_res),
        .buttons    (buttons)
    );

    always #5 clk = ~clk;

    // Picks the next tick word. Well-formed traffic starts reads from idle and plays
    // back a chosen button pattern on the data line while the pad clock is low.
    function automatic void pick_tick(bit well_formed, output bit st, output bit dt);
        dt = 1'($urandom_range(0, 1));
        if (!well_formed) begin
            st = ($urandom_range(0, 3) == 0);
            return;
        end
        case (sb.phase)
            RD_IDLE: begin
                st = ($urandom_range(0, 9) != 0);
                if (st) begin
                    pad_pressed = snes_pkg::SERIAL_BITS'($urandom);
                    pad_pressed[snes_pkg::SERIAL_BITS-1] = ($urandom_range(0, 4) != 0);
                end
            end
            RD_LOW: begin
                st = ($urandom_range(0, 19) == 0);
                dt = !pad_pressed[sb.bit_pos];
            end
            RD_HIGH:
                // Near the end of a read, also try a start on the done tick itself.
                st = (sb.bit_pos == snes_pkg::SERIAL_BITS - 1) ? 1'($urandom_range(0, 1))
                                                                : ($urandom_range(0, 19) == 0);
            default:
                st = ($urandom_range(0, 19) == 0);
        endcase
    endfunction

    task automatic offer_tick(bit st, bit dt);
        in_valid <= 1'b1;
        start_read <= st;
        data_line <= dt;
        do @(posedge clk); while (!in_ready);
        sb.note_tick(st, dt);
        ticks_sent++;
    endtask

    task automatic send_ticks(int count, bit well_formed);
        int i;
        bit st;
        bit dt;
        for (i = 0; i < count; i++) begin
            if (!(ticks_sent >= 500 && ticks_sent < 700) && $urandom_range(0, 99) < 7) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            pick_tick(well_formed, st, dt);
            offer_tick(st, dt);
        end
        in_valid <= 1'b0;
    endtask

    // Returns on a rising edge once every expected word has come back.
    task automatic wait_drained();
        do @(negedge clk); while (sb.pending() != 0);
        @(posedge clk);
    endtask

    task automatic write_half(bit [snes_pkg::HALF_W-1:0] v);
        cfg_data <= v;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_half(v);
    endtask

    always @(posedge clk) begin
        if (out_valid && out_ready) begin
            sb.check_word(latch_out, clock_out, busy_res, done_res, buttons);
            words_seen++;
        end
        // One long stall on the result side lets the block back up into its input.
        if (words_seen == 450 && !held_once) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (words_seen >= 500 && words_seen < 700)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= 7);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int i;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle ticks with both data levels, a start, then a start while busy.
        offer_tick(1'b0, 1'b0);
        offer_tick(1'b0, 1'b1);
        offer_tick(1'b1, 1'b1);
        offer_tick(1'b1, 1'b0);
        for (i = 0; i < 20; i++)
            offer_tick(1'($urandom_range(0, 1)), i[0]);
        in_valid <= 1'b0;

        // The read above is still running; period changes take effect mid-read.
        wait_drained();
        write_half(16'd0);
        send_ticks(120, 1'b1);
        wait_drained();
        write_half(16'hFFFF);
        send_ticks(40, 1'b1);
        wait_drained();
        write_half(16'd1);
        send_ticks(250, 1'b1);
        wait_drained();
        send_ticks(60, 1'b0);
        wait_drained();
        write_half(16'd2);
        send_ticks(220, 1'b1);
        wait_drained();
        write_half(16'd3);
        send_ticks(100, 1'b1);
        wait_drained();
        write_half(16'd1);
        send_ticks(40, 1'b0);

        wait_drained();
        repeat (4) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
hdl/snes_pkg.sv
hdl/snes_pad_reader.sv
verif/tb.sv
